// ----- rtl/core/mlr_pkg.sv -----
`default_nettype none

package mlr_pkg;

    localparam int COORD_W    = 6;
    localparam int SEG_W      = 4 * COORD_W;
    localparam int ROW_MASK_W = 64;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // segment transfer: clamp, seed queue, first end point
        logic mark_end2;   // move the mark point to the second end point
        logic calc;        // pop queue head, form midpoint
        logic push1;       // queue first half if it is long enough
        logic push2;       // queue second half if it is long enough
        logic bm_write;    // write back the marked bitmap row
        logic sel_row;     // bitmap read address from the row counter
        logic out_load;    // move one row into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic q_empty;
        logic out_free;
        logic row_last;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/mlr_ram.sv -----
`default_nettype none

module mlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/mlr_ctrl.sv -----
`default_nettype none

module mlr_ctrl
    import mlr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_END_RD0,
        ST_END_WR0,
        ST_END_RD1,
        ST_END_WR1,
        ST_POP,
        ST_CALC,
        ST_MID_RD,
        ST_MID_WR,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_item = s_tvalid;
                if (s_tvalid) state_next = ST_END_RD0;
            end
            ST_END_RD0: state_next = ST_END_WR0;
            ST_END_WR0: begin
                cmd.bm_write  = 1'b1;
                cmd.mark_end2 = 1'b1;
                state_next    = ST_END_RD1;
            end
            ST_END_RD1: state_next = ST_END_WR1;
            ST_END_WR1: begin
                cmd.bm_write = 1'b1;
                state_next   = ST_POP;
            end
            // queue read of the head entry is in flight during this state
            ST_POP: state_next = status.q_empty ? ST_OUT_RD : ST_CALC;
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_MID_RD;
            end
            ST_MID_RD: begin
                cmd.push1  = 1'b1;
                state_next = ST_MID_WR;
            end
            ST_MID_WR: begin
                cmd.bm_write = 1'b1;
                cmd.push2    = 1'b1;
                state_next   = ST_POP;
            end
            ST_OUT_RD: begin
                cmd.sel_row = 1'b1;
                state_next  = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                cmd.sel_row = 1'b1;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.row_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/mlr_datapath.sv -----
`default_nettype none

module mlr_datapath
    import mlr_pkg::*;
#(
    parameter int GRID_SIZE   = 64,
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic [COORD_W-1:0]    start_x,
    input  wire logic [COORD_W-1:0]    start_y,
    input  wire logic [COORD_W-1:0]    end_x,
    input  wire logic [COORD_W-1:0]    end_y,
    input  wire logic                  m_tready,
    output logic                       out_valid,
    output logic [COORD_W-1:0]         row_index,
    output logic [ROW_MASK_W-1:0]      row_mask,
    output logic                       last_row
);

    localparam int RowW = $clog2(GRID_SIZE);
    localparam int QaW  = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
        return ({1'b0, v} >= (COORD_W+1)'(GRID_SIZE)) ? COORD_W'(GRID_SIZE - 1) : v;
    endfunction

    function automatic logic [COORD_W-1:0] mid(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
        logic [COORD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b} + (COORD_W+1)'(1);
        return sum[COORD_W:1];
    endfunction

    function automatic logic far(input logic [COORD_W-1:0] a,
                                 input logic [COORD_W-1:0] b);
        logic [COORD_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > COORD_W'(1);
    endfunction

    function automatic logic [QaW-1:0] ptr_inc(input logic [QaW-1:0] p);
        return (p == QaW'(QUEUE_DEPTH - 1)) ? '0 : p + QaW'(1);
    endfunction

    logic [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [COORD_W-1:0] mx_reg, my_reg, ex_reg, ey_reg;
    logic [RowW-1:0]    maxy_reg, row_reg;
    logic [QaW-1:0]     head_reg, tail_reg;
    logic [CntW-1:0]    count_reg;
    logic [GRID_SIZE-1:0] row_valid_reg;
    logic               out_valid_reg;
    logic [RowW-1:0]    out_row_reg;
    logic [GRID_SIZE-1:0] out_mask_reg;
    logic               out_last_reg;

    logic [COORD_W-1:0] cx, cy, cex, cey;
    logic [SEG_W-1:0]   q_rdata, q_wdata;
    logic [QaW-1:0]     q_waddr;
    logic               q_we, q_room, half1, half2;
    logic [RowW-1:0]    bm_raddr, my_row;
    logic [GRID_SIZE-1:0] bm_rdata, bm_row, bm_wdata;
    logic [COORD_W-1:0] qx1, qy1, qx2, qy2;

    assign cx  = clamp(start_x);
    assign cy  = clamp(start_y);
    assign cex = clamp(end_x);
    assign cey = clamp(end_y);

    assign {qx1, qy1, qx2, qy2} = q_rdata;

    assign q_room = (count_reg < CntW'(QUEUE_DEPTH));
    assign half1  = far(mx_reg, x1_reg) || far(my_reg, y1_reg);
    assign half2  = far(mx_reg, x2_reg) || far(my_reg, y2_reg);

    always_comb begin
        q_we    = 1'b0;
        q_waddr = tail_reg;
        q_wdata = {mx_reg, my_reg, x2_reg, y2_reg};
        if (cmd.load_item) begin
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = {cx, cy, cex, cey};
        end else if (cmd.push1) begin
            q_we    = half1 && q_room;
            q_wdata = {x1_reg, y1_reg, mx_reg, my_reg};
        end else if (cmd.push2) begin
            q_we = half2 && q_room;
        end
    end

    mlr_ram #(
        .WIDTH (SEG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    assign my_row   = my_reg[RowW-1:0];
    assign bm_raddr = cmd.sel_row ? row_reg : my_row;

    // rows not written since the segment started read as empty
    assign bm_row   = row_valid_reg[bm_raddr] ? bm_rdata : '0;
    assign bm_wdata = bm_row | (GRID_SIZE'(1) << mx_reg);

    mlr_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (cmd.bm_write),
        .waddr (my_row),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mx_reg   <= cx;
            my_reg   <= cy;
            ex_reg   <= cex;
            ey_reg   <= cey;
            maxy_reg <= (cy > cey) ? cy[RowW-1:0] : cey[RowW-1:0];
        end
        if (cmd.mark_end2) begin
            mx_reg <= ex_reg;
            my_reg <= ey_reg;
        end
        if (cmd.calc) begin
            x1_reg <= qx1;
            y1_reg <= qy1;
            x2_reg <= qx2;
            y2_reg <= qy2;
            mx_reg <= mid(qx1, qx2);
            my_reg <= mid(qy1, qy2);
        end
        if (cmd.out_load) begin
            out_row_reg  <= row_reg;
            out_mask_reg <= bm_row;
            out_last_reg <= status.row_last;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            row_reg       <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                head_reg      <= '0;
                tail_reg      <= QaW'(1);
                count_reg     <= CntW'(1);
                row_reg       <= '0;
                row_valid_reg <= '0;
            end else begin
                if (cmd.calc) begin
                    head_reg  <= ptr_inc(head_reg);
                    count_reg <= count_reg - CntW'(1);
                end
                if ((cmd.push1 || cmd.push2) && q_we) begin
                    tail_reg  <= ptr_inc(tail_reg);
                    count_reg <= count_reg + CntW'(1);
                end
                if (cmd.bm_write) begin
                    row_valid_reg[my_row] <= 1'b1;
                end
                if (cmd.out_load) begin
                    row_reg <= row_reg + RowW'(1);
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.q_empty  = (count_reg == '0);
    assign status.out_free = !out_valid_reg || m_tready;
    assign status.row_last = (row_reg == maxy_reg);

    assign out_valid = out_valid_reg;
    assign row_index = COORD_W'(out_row_reg);
    assign row_mask  = ROW_MASK_W'(out_mask_reg);
    assign last_row  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.calc |-> count_reg != '0)
        else $error("pop from empty queue");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> row_reg <= maxy_reg)
        else $error("row emitted beyond last row");

endmodule

`default_nettype wire

// ----- rtl/core/midpoint_line_rasterizer_top.sv -----
`default_nettype none

// Midpoint-subdivision line rasterizer.
// Slave stream: one transfer per segment, s_tdata = {end_y, end_x, start_y, start_x}.
// Master stream: one transfer per bitmap row, rows 0 up to max(start_y, end_y);
// m_tdata carries the row index and the 64-bit row mask, m_tlast marks the final row.
// Coordinates at or above GRID_SIZE are saturated to GRID_SIZE-1.
// Per segment: the transfer, then both end points are marked in the bitmap, then
// each queue entry is visited in turn (empty check, pop with midpoint, bitmap read,
// bitmap write) until the queue is found empty (one shared bitmap read-modify-write
// port and one queue port), then each row is read from the bitmap and loaded for
// output. The queue entries visited are about the cells on the line; a stalling
// receiver lengthens the row emission.
// s_tready is high only between segments. A finished row sits in an output
// register, so the next segment can be taken while the last row still waits.
// A stalled receiver holds off the row emission; nothing is dropped.
// Reset (aresetn low, synchronous) empties the queue and output register; the
// bitmap needs no clearing pass, per-row valid bits are cleared for each segment.
module midpoint_line_rasterizer_top
    import mlr_pkg::*;
#(
    parameter int GRID_SIZE   = 64,
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // start_x, start_y, end_x, end_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // row_index, row_mask, zero pad
    output logic             m_tlast    // last_row
);

    cmd_t    cmd;
    status_t status;

    logic [COORD_W-1:0]    row_index;
    logic [ROW_MASK_W-1:0] row_mask;

    mlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mlr_datapath #(
        .GRID_SIZE   (GRID_SIZE),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .start_x   (s_tdata[5:0]),
        .start_y   (s_tdata[11:6]),
        .end_x     (s_tdata[17:12]),
        .end_y     (s_tdata[23:18]),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .row_index (row_index),
        .row_mask  (row_mask),
        .last_row  (m_tlast)
    );

    assign m_tdata = {2'b00, row_mask, row_index};

endmodule

`default_nettype wire
